// ===== design/mpe_pkg.sv =====
// Package for the mosaic pixelate engine: item types, codes, controller states,
// controller/datapath command and status structs, and the divide-by-five helper.
// No dependencies.
package mpe_pkg;

	// Storage defaults
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;

	// Field widths
	localparam int PIX_W   = 9;   // pos_x / pos_y
	localparam int BS_W    = 8;   // block_size
	localparam int DIM_W   = 10;  // frame_width / frame_height
	localparam int COORD_W = 10;  // sample coordinate, origin plus offset
	localparam int LIN_W   = 20;  // linear sample address and frame area
	localparam int CH_W    = 8;   // one colour channel
	localparam int SUM_W   = 11;  // sum of five channel values
	localparam int CFG_IDX_W = 2;

	// Reset values of the registers
	localparam logic [BS_W-1:0]  BLOCK_SIZE_RST   = 8'd16;
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 10'd512;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 10'd512;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

	// Item operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Sample order
	localparam int SMP_W = 3;
	localparam logic [SMP_W-1:0] SMP_TOP_LEFT     = 3'd0;
	localparam logic [SMP_W-1:0] SMP_TOP_RIGHT    = 3'd1;
	localparam logic [SMP_W-1:0] SMP_CENTRE       = 3'd2;
	localparam logic [SMP_W-1:0] SMP_BOTTOM_LEFT  = 3'd3;
	localparam logic [SMP_W-1:0] SMP_BOTTOM_RIGHT = 3'd4;

	// Divide by five: floor(x * 1639 / 2^13) is exact for x below 2730
	localparam int DIV5_W = 22;
	localparam logic [DIV5_W-1:0] DIV5_RECIP = 22'd1639;
	localparam int DIV5_SHIFT = 13;

	typedef struct packed {
		logic            op;
		logic [PIX_W-1:0] pos_x;
		logic [PIX_W-1:0] pos_y;
		logic [CH_W-1:0]  red_in;
		logic [CH_W-1:0]  green_in;
		logic [CH_W-1:0]  blue_in;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_ADDR,
		ST_LD_WRITE,
		ST_DIV,
		ST_SMP_COORD,
		ST_SMP_ADDR,
		ST_SMP_CHECK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;   // take in a new item
		logic div_step;  // one remainder bit for x and y
		logic coord;     // register the current sample's coordinates
		logic addr;      // register the linear address
		logic wr;        // write the loaded pixel
		logic rd;        // read the current sample
		logic smp_next;  // move to the next sample
		logic emit;      // load the output register
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
		logic in_range;
		logic smp_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [CH_W-1:0] div5(input logic [SUM_W-1:0] x);
		logic [DIV5_W-1:0] p;
		p = DIV5_W'(x) * DIV5_RECIP;
		return p[DIV5_SHIFT +: CH_W];
	endfunction

endpackage

// ===== design/mpe_ctrl.sv =====
// Controller of the mosaic pixelate engine: sequences loads and queries.
// Depends on mpe_pkg.
module mpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_stall,
	input  mpe_pkg::dp_sts_t  sts,
	output mpe_pkg::dp_cmd_t  cmd
);

	mpe_pkg::state_t state_q, state_nxt;
	logic accept;

	assign accept = in_valid && (state_q == mpe_pkg::ST_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mpe_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = (in_op == mpe_pkg::OP_QUERY) ? mpe_pkg::ST_DIV
						: mpe_pkg::ST_LD_ADDR;
				end
			end
			mpe_pkg::ST_LD_ADDR:   state_nxt = mpe_pkg::ST_LD_WRITE;
			mpe_pkg::ST_LD_WRITE:  state_nxt = mpe_pkg::ST_IDLE;
			mpe_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = mpe_pkg::ST_SMP_COORD;
				end
			end
			mpe_pkg::ST_SMP_COORD: state_nxt = mpe_pkg::ST_SMP_ADDR;
			mpe_pkg::ST_SMP_ADDR:  state_nxt = mpe_pkg::ST_SMP_CHECK;
			mpe_pkg::ST_SMP_CHECK: begin
				// first sample beyond the frame ends accumulation
				if (!sts.in_range) begin
					state_nxt = mpe_pkg::ST_FINISH;
				end else if (sts.smp_last) begin
					state_nxt = mpe_pkg::ST_DRAIN;
				end else begin
					state_nxt = mpe_pkg::ST_SMP_COORD;
				end
			end
			mpe_pkg::ST_DRAIN:     state_nxt = mpe_pkg::ST_FINISH;
			mpe_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = mpe_pkg::ST_IDLE;
				end
			end
			default:               state_nxt = mpe_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall     = (state_q != mpe_pkg::ST_IDLE);
		cmd          = '0;
		cmd.capture  = accept;
		cmd.div_step = (state_q == mpe_pkg::ST_DIV);
		cmd.coord    = (state_q == mpe_pkg::ST_SMP_COORD);
		cmd.addr     = (state_q == mpe_pkg::ST_LD_ADDR) || (state_q == mpe_pkg::ST_SMP_ADDR);
		cmd.wr       = (state_q == mpe_pkg::ST_LD_WRITE) && sts.in_range;
		cmd.rd       = (state_q == mpe_pkg::ST_SMP_CHECK) && sts.in_range;
		cmd.smp_next = (state_q == mpe_pkg::ST_SMP_CHECK) && sts.in_range && !sts.smp_last;
		cmd.emit     = (state_q == mpe_pkg::ST_FINISH) && sts.out_free;
	end

endmodule

// ===== design/mpe_datapath.sv =====
// Datapath of the mosaic pixelate engine: registers, frame store, remainder
// unit, address multiplier, accumulators and output register. Depends on mpe_pkg.
module mpe_datapath #(
	parameter int MAX_WIDTH  = mpe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mpe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpe_pkg::DIM_W-1:0]         cfg_data,
	input  mpe_pkg::in_item_t                 in_item,
	input  mpe_pkg::dp_cmd_t                  cmd,
	output mpe_pkg::dp_sts_t                  sts,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mpe_pkg::out_item_t                out_item
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int EXT_W  = mpe_pkg::LIN_W + ADDR_W;
	localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DEPTH);
	localparam int PW = mpe_pkg::PIX_W;

	// Registers
	logic [mpe_pkg::BS_W-1:0]    block_size_q;
	logic [mpe_pkg::DIM_W-1:0]   frame_width_q, frame_height_q;
	logic [mpe_pkg::LIN_W-1:0]   lim_q;
	logic [PW-1:0]               px_q, py_q, dx_q, dy_q, rx_q, ry_q;
	logic [3*mpe_pkg::CH_W-1:0]  rgb_q, rd_data_q;
	logic [3:0]                  div_cnt_q;
	logic [mpe_pkg::SMP_W-1:0]   smp_q;
	logic [mpe_pkg::COORD_W-1:0] sx_q, sy_q;
	logic [mpe_pkg::LIN_W-1:0]   a_q;
	logic                        rd_pend_q;
	logic [mpe_pkg::SUM_W-1:0]   r_sum_q, g_sum_q, b_sum_q;
	logic                        out_valid_q;
	mpe_pkg::out_item_t          out_item_q;
	logic [3*mpe_pkg::CH_W-1:0]  mem [DEPTH];

	// Combinational
	logic [mpe_pkg::BS_W-1:0]    bs_eff, half;
	logic [PW-1:0]               rx_sh, ry_sh, rx_nxt, ry_nxt, bs_ext, ox, oy;
	logic [mpe_pkg::BS_W-1:0]    off_x, off_y;
	logic [mpe_pkg::LIN_W-1:0]   prod;
	logic [EXT_W-1:0]            a_ext;
	logic [ADDR_W-1:0]           mem_idx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= mpe_pkg::BLOCK_SIZE_RST;
			frame_width_q  <= mpe_pkg::FRAME_WIDTH_RST;
			frame_height_q <= mpe_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mpe_pkg::CFG_BLOCK_SIZE:   block_size_q   <= cfg_data[mpe_pkg::BS_W-1:0];
				mpe_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				mpe_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame area, refreshed every cycle
	always_ff @(posedge clk) begin
		lim_q <= frame_width_q * frame_height_q;
	end

	// Remainder unit: one quotient bit per cycle for x and y together
	assign bs_eff = (block_size_q == '0) ? mpe_pkg::BS_W'(1) : block_size_q;
	assign half   = bs_eff >> 1;
	assign bs_ext = {1'b0, bs_eff};
	assign rx_sh  = {rx_q[PW-2:0], dx_q[PW-1]};
	assign ry_sh  = {ry_q[PW-2:0], dy_q[PW-1]};
	assign rx_nxt = (rx_sh >= bs_ext) ? rx_sh - bs_ext : rx_sh;
	assign ry_nxt = (ry_sh >= bs_ext) ? ry_sh - bs_ext : ry_sh;

	// Square origin and sample offsets
	assign ox = px_q - rx_q;
	assign oy = py_q - ry_q;
	always_comb begin
		case (smp_q)
			mpe_pkg::SMP_TOP_LEFT:     begin off_x = '0;     off_y = '0;     end
			mpe_pkg::SMP_TOP_RIGHT:    begin off_x = bs_eff; off_y = '0;     end
			mpe_pkg::SMP_CENTRE:       begin off_x = half;   off_y = half;   end
			mpe_pkg::SMP_BOTTOM_LEFT:  begin off_x = '0;     off_y = bs_eff; end
			mpe_pkg::SMP_BOTTOM_RIGHT: begin off_x = bs_eff; off_y = bs_eff; end
			default:                   begin off_x = '0;     off_y = '0;     end
		endcase
	end

	// Linear address and bound check
	assign prod    = sy_q * frame_width_q;
	assign a_ext   = EXT_W'(a_q);
	assign mem_idx = a_ext[ADDR_W-1:0];

	always_comb begin
		sts.div_last = (div_cnt_q == 4'(PW - 1));
		sts.in_range = (a_q < lim_q) && (a_ext < DEPTH_EXT);
		sts.smp_last = (smp_q == mpe_pkg::SMP_BOTTOM_RIGHT);
		sts.out_free = !out_valid_q || !out_stall;
	end

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			smp_q     <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.rd;
			if (cmd.capture) begin
				div_cnt_q <= '0;
				smp_q     <= '0;
			end else begin
				if (cmd.div_step) begin
					div_cnt_q <= div_cnt_q + 4'd1;
				end
				if (cmd.smp_next) begin
					smp_q <= smp_q + mpe_pkg::SMP_W'(1);
				end
			end
		end
	end

	// Item capture, remainder steps, coordinates, address, accumulation
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q    <= in_item.pos_x;
			py_q    <= in_item.pos_y;
			dx_q    <= in_item.pos_x;
			dy_q    <= in_item.pos_y;
			rx_q    <= '0;
			ry_q    <= '0;
			rgb_q   <= {in_item.red_in, in_item.green_in, in_item.blue_in};
			sx_q    <= {1'b0, in_item.pos_x};
			sy_q    <= {1'b0, in_item.pos_y};
			r_sum_q <= '0;
			g_sum_q <= '0;
			b_sum_q <= '0;
		end else begin
			if (cmd.div_step) begin
				rx_q <= rx_nxt;
				ry_q <= ry_nxt;
				dx_q <= dx_q << 1;
				dy_q <= dy_q << 1;
			end
			if (cmd.coord) begin
				sx_q <= {1'b0, ox} + {2'b00, off_x};
				sy_q <= {1'b0, oy} + {2'b00, off_y};
			end
			if (rd_pend_q) begin
				r_sum_q <= r_sum_q + mpe_pkg::SUM_W'(rd_data_q[23:16]);
				g_sum_q <= g_sum_q + mpe_pkg::SUM_W'(rd_data_q[15:8]);
				b_sum_q <= b_sum_q + mpe_pkg::SUM_W'(rd_data_q[7:0]);
			end
		end
		if (cmd.addr) begin
			a_q <= prod + mpe_pkg::LIN_W'(sx_q);
		end
	end

	// Frame store, one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[mem_idx] <= rgb_q;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[mem_idx];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item_q.red_out   <= mpe_pkg::div5(r_sum_q);
			out_item_q.green_out <= mpe_pkg::div5(g_sum_q);
			out_item_q.blue_out  <= mpe_pkg::div5(b_sum_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== design/mosaic_pixelate_engine_core.sv =====
// Top level of the mosaic pixelate engine: controller plus datapath.
// Depends on mpe_pkg, mpe_ctrl and mpe_datapath.
//
// Usage
//   Input channel (in_valid / in_stall / in_item): a load item writes one RGB
//   pixel to the frame store at pos_y*frame_width+pos_x and gives no result;
//   a query item gives one result, the sum of five samples of its mosaic
//   square divided by five (summing stops at a sample beyond the frame).
//   Output channel (out_valid / out_stall / out_item): one item per query.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
//   block_size, 1 frame_width, 2 frame_height. cfg_ready is always high;
//   write only while the block is idle.
// Sequencing
//   A load registers its address, then writes the pixel if the address
//   lies within the frame. A query runs the 9-step bit-serial remainder
//   unit and then, per sample, registers the coordinates and the address
//   multiply and does a single-port store read; it ends early when a
//   sample falls beyond the frame. The next item waits until idle.
// Reset and stalls
//   Reset restores the register defaults and empties the output register;
//   the frame store is not cleared. A result held by out_stall sits in the
//   output register; the block keeps taking loads, and a following query
//   waits at its end until the output register is free.
module mosaic_pixelate_engine_core #(
	parameter int MAX_WIDTH  = mpe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mpe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mpe_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mpe_pkg::out_item_t            out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpe_pkg::DIM_W-1:0]     cfg_data
);

	mpe_pkg::dp_cmd_t cmd;
	mpe_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	mpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_item.op),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mpe_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== design/mpe_checker.sv =====
// Port-level checker for the mosaic pixelate engine, bound to the top level.
// Depends on mpe_pkg and mosaic_pixelate_engine_core.
module mpe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input mpe_pkg::in_item_t             in_item,
	input logic                          out_valid,
	input logic                          out_stall,
	input mpe_pkg::out_item_t            out_item,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [mpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mpe_pkg::DIM_W-1:0]     cfg_data
);

	// A held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// The input is stalled in the cycle after an item is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after acceptance");

	// A new result only appears at the end of a query's work
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while idle");

	// A load never raises a result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_item.op == mpe_pkg::OP_LOAD) |=> !$rose(out_valid))
		else $error("result raised after a load");

endmodule

bind mosaic_pixelate_engine_core mpe_checker u_mpe_checker (.*);
